>>> rtl/core/block_rms_level_smoother_defines.svh
// Assertion macros for the block RMS level smoother.
// Depends on signals named clk and arst_n in the module that uses them.
`ifndef BLOCK_RMS_LEVEL_SMOOTHER_DEFINES_SVH
`define BLOCK_RMS_LEVEL_SMOOTHER_DEFINES_SVH

// property checked on every rising clk edge outside reset
`define BRLS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen
`define BRLS_ASSERT_NEVER(lbl, cond, msg) \
	`BRLS_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/core/brls_pkg.sv
// Shared constants and width helpers for the block RMS level smoother.
// No dependencies.
package brls_pkg;

	localparam int SAMPLE_W      = 16;   // width of the sample field
	localparam int SAMPLE_BITS   = 16;   // bits of the field that carry the sample
	localparam int LEVEL_W       = 16;
	localparam int WEIGHT_W      = 16;
	localparam int WEIGHT_FRAC   = 16;
	localparam int MUL_W         = 17;   // operand width of the shared multiplier
	localparam int ACC_W         = 2 * MUL_W;
	localparam int MAX_BLOCK_DEF = 4096;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd9830;
	localparam logic [MUL_W-1:0]    WEIGHT_ONE   = 17'd65536;
	localparam logic [ACC_W-1:0]    ROUND_HALF   = 34'd32768;
	localparam logic [LEVEL_W-1:0]  RMS_MAX      = 16'd32768;

	function automatic int cnt_width(int max_block);
		return $clog2(max_block + 1);
	endfunction

	// squares are at most 2^(2*SAMPLE_BITS-2), one spare bit keeps room for the root
	function automatic int sum_width(int max_block);
		return $clog2(max_block + 1) + 2 * SAMPLE_BITS - 1;
	endfunction

endpackage

>>> rtl/core/brls_stream_ifs.sv
// Valid/ready channel interfaces: sample input, level output, weight write.
// Depends on brls_pkg.
interface brls_in_if import brls_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_sample;
	modport source (output valid, sample, last_sample, input ready);
	modport sink (input valid, sample, last_sample, output ready);
endinterface

interface brls_out_if import brls_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] level;
	logic               overrun;
	modport source (output valid, level, overrun, input ready);
	modport sink (input valid, level, overrun, output ready);
endinterface

interface brls_cfg_if import brls_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [WEIGHT_W-1:0] smoothing_weight;
	modport source (output valid, smoothing_weight, input ready);
	modport sink (input valid, smoothing_weight, output ready);
endinterface

>>> rtl/core/brls_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on brls_pkg.
module brls_mul import brls_pkg::*; #(
	parameter int W = MUL_W
) (
	input  logic           clk,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

>>> rtl/core/brls_root.sv
// Iterative mean and root unit: restoring divide of the square sum by the
// count, then digit-by-digit integer square root, one shared compare-subtract.
// Depends on brls_pkg.
module brls_root import brls_pkg::*; #(
	parameter int MAX_BLOCK = MAX_BLOCK_DEF,
	localparam int CNT_W = cnt_width(MAX_BLOCK),
	localparam int SUM_W = sum_width(MAX_BLOCK)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SUM_W-1:0]       square_sum,
	input  logic [CNT_W-1:0]       sample_count,
	output logic                   done,
	output logic [SAMPLE_BITS-1:0] root
);

	localparam int CMP_W = (CNT_W + 1 > SAMPLE_BITS + 2) ? CNT_W + 1 : SAMPLE_BITS + 2;
	localparam int IT_W  = $clog2(SUM_W);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DIV  = 2'd1;
	localparam logic [1:0] PH_SQRT = 2'd2;

	logic [1:0]             phase_q;
	logic [IT_W-1:0]        it_q;
	logic                   done_q;
	logic [SUM_W-1:0]       dq_q;    // dividend, then quotient, then root operand
	logic [CNT_W-1:0]       div_q;
	logic [CMP_W-1:0]       rem_q;
	logic [SAMPLE_BITS-1:0] root_q;

	logic [CMP_W-1:0] rem_div;
	logic [CMP_W-1:0] rem_sq;
	logic [CMP_W-1:0] op_a;
	logic [CMP_W-1:0] op_b;
	logic [CMP_W:0]   diff;
	logic             ge;

	always_comb begin
		rem_div = {rem_q[CMP_W-2:0], dq_q[SUM_W-1]};
		rem_sq  = {rem_q[CMP_W-3:0], dq_q[2*SAMPLE_BITS-1 -: 2]};
		if (phase_q == PH_SQRT) begin
			op_a = rem_sq;
			op_b = CMP_W'({root_q, 2'b01});
		end else begin
			op_a = rem_div;
			op_b = CMP_W'(div_q);
		end
		diff = {1'b0, op_a} - {1'b0, op_b};
		ge   = !diff[CMP_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			it_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_DIV;
						it_q    <= '0;
					end
				end
				PH_DIV: begin
					if (it_q == IT_W'(SUM_W - 1)) begin
						phase_q <= PH_SQRT;
						it_q    <= '0;
					end else begin
						it_q <= it_q + IT_W'(1);
					end
				end
				PH_SQRT: begin
					if (it_q == IT_W'(SAMPLE_BITS - 1)) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end else begin
						it_q <= it_q + IT_W'(1);
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			PH_IDLE: begin
				if (start) begin
					dq_q  <= square_sum;
					div_q <= sample_count;
					rem_q <= '0;
				end
			end
			PH_DIV: begin
				dq_q <= {dq_q[SUM_W-2:0], ge};
				if (it_q == IT_W'(SUM_W - 1)) begin
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					rem_q <= ge ? diff[CMP_W-1:0] : op_a;
				end
			end
			PH_SQRT: begin
				rem_q  <= ge ? diff[CMP_W-1:0] : op_a;
				root_q <= {root_q[SAMPLE_BITS-2:0], ge};
				dq_q   <= {dq_q[SUM_W-3:0], 2'b00};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> rtl/core/block_rms_level_smoother.sv
// Top level of the block RMS level smoother: sequencer, accumulator, smoothing.
// Depends on brls_pkg, brls_stream_ifs, brls_mul, brls_root and the defines header.
//
// Usage: samples enter on smp (sample, last_sample) one at a time while a block
// is being summed; each sample's square comes from the shared multiplier and is
// added to the running sum the next cycle, with smp.ready low until then. The
// item carrying last_sample ends the block: the mean square is divided out one
// quotient bit a cycle over the sum width, the root of SAMPLE_BITS bits follows,
// and the smoothing multiply-adds run on the same multiplier. smp.ready stays
// low until the level item is in the output register. Samples past MAX_BLOCK
// in one block are dropped and the result carries overrun. A finished level
// waits in the output register; a stalled res holds the sequencer only at its
// final step. cfg writes the smoothing weight and is always ready.
// Reset clears sum, count, level and overrun and sets the weight to 0.15.
`include "block_rms_level_smoother_defines.svh"
module block_rms_level_smoother import brls_pkg::*; #(
	parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
	input logic      clk,
	input logic      arst_n,
	brls_in_if.sink  smp,
	brls_out_if.source res,
	brls_cfg_if.sink cfg
);

	localparam int CNT_W = cnt_width(MAX_BLOCK);
	localparam int SUM_W = sum_width(MAX_BLOCK);
	localparam int RSH   = (SAMPLE_BITS >= LEVEL_W) ? SAMPLE_BITS - LEVEL_W : 0;
	localparam int LSH   = (SAMPLE_BITS < LEVEL_W) ? LEVEL_W - SAMPLE_BITS : 0;
	localparam int RMS_W = LEVEL_W + SAMPLE_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ACC   = 3'd1;
	localparam logic [2:0] ST_DIVGO = 3'd2;
	localparam logic [2:0] ST_ROOT  = 3'd3;
	localparam logic [2:0] ST_MUL1  = 3'd4;
	localparam logic [2:0] ST_MUL2  = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]          state_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                ovr_q;
	logic                last_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [ACC_W-1:0]    acc_q;
	logic                out_valid_q;
	logic [LEVEL_W-1:0]  level_out_q;
	logic                ovr_out_q;

	logic [SAMPLE_BITS-1:0] raw;
	logic [SAMPLE_BITS-1:0] mag;
	logic [MUL_W-1:0]       mul_a;
	logic [MUL_W-1:0]       mul_b;
	logic [ACC_W-1:0]       mul_p;
	logic                   root_done;
	logic [SAMPLE_BITS-1:0] root;
	logic [RMS_W-1:0]       rms_wide;
	logic [LEVEL_W-1:0]     rms;
	logic [ACC_W-1:0]       acc_sum;
	logic [LEVEL_W-1:0]     new_level;

	// two's complement magnitude; the most negative code maps to 2^(bits-1)
	assign raw = smp.sample[SAMPLE_BITS-1:0];
	assign mag = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;

	always_comb begin
		rms_wide = (RMS_W'(root) >> RSH) << LSH;
		rms      = (rms_wide > RMS_W'(RMS_MAX)) ? RMS_MAX : LEVEL_W'(rms_wide);
	end

	always_comb begin
		unique case (state_q)
			ST_MUL1: begin
				mul_a = MUL_W'(level_q);
				mul_b = WEIGHT_ONE - MUL_W'(weight_q);
			end
			ST_MUL2, ST_OUT: begin
				mul_a = MUL_W'(rms);
				mul_b = MUL_W'(weight_q);
			end
			default: begin
				mul_a = MUL_W'(mag);
				mul_b = MUL_W'(mag);
			end
		endcase
	end

	assign acc_sum   = acc_q + mul_p + ROUND_HALF;
	assign new_level = acc_sum[WEIGHT_FRAC +: LEVEL_W];

	brls_mul #(.W(MUL_W)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	brls_root #(.MAX_BLOCK(MAX_BLOCK)) u_root (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (state_q == ST_DIVGO),
		.square_sum   (sum_q),
		.sample_count (cnt_q),
		.done         (root_done),
		.root         (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			ovr_q       <= 1'b0;
			last_q      <= 1'b0;
			level_q     <= '0;
			weight_q    <= WEIGHT_RESET;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			level_out_q <= '0;
			ovr_out_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				weight_q <= cfg.smoothing_weight;
			end
			// ST_OUT reloads the output register itself
			if (out_valid_q && res.ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (smp.valid) begin
						last_q  <= smp.last_sample;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (cnt_q < CNT_W'(MAX_BLOCK)) begin
						sum_q <= sum_q + SUM_W'(mul_p);
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						ovr_q <= 1'b1;
					end
					state_q <= last_q ? ST_DIVGO : ST_IDLE;
				end
				ST_DIVGO: begin
					// root unit latches sum and count on this edge
					sum_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_done) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: begin
					acc_q   <= mul_p;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || res.ready) begin
						level_q     <= new_level;
						level_out_q <= new_level;
						ovr_out_q   <= ovr_q;
						ovr_q       <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign smp.ready   = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;
	assign res.valid   = out_valid_q;
	assign res.level   = level_out_q;
	assign res.overrun = ovr_out_q;

	`BRLS_ASSERT(a_level_range, res.valid |-> (res.level <= RMS_MAX), "level above 1.0")
	`BRLS_ASSERT(a_count_range, cnt_q <= CNT_W'(MAX_BLOCK), "sample count past block limit")
	`BRLS_ASSERT(a_busy_after_start, (state_q == ST_DIVGO) |=> !smp.ready, "ready during root")
	`BRLS_ASSERT_NEVER(a_stray_done, root_done && (state_q != ST_ROOT), "root done while not waiting")

endmodule
